/* design/ncl_pkg.sv */
// Shared types and constants for the nearest centroid labeler.
`timescale 1ns / 1ps

package ncl_pkg;

    // Fixed field widths of the transfer payloads
    localparam int COORD_W  = 8;
    localparam int NIDX_W   = 7;
    localparam int LIMIT_W  = 17;
    localparam int REQ_W    = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd20000;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // Register index, taken from paddr bit 2
    localparam logic REG_LIMIT = 1'b0;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } t_ncl_req;

    typedef struct packed {
        logic [NIDX_W-1:0] nearest_index;
        logic              found;
    } t_ncl_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_ncl_state;

endpackage

/* design/ncl_cfg.sv */
// APB register block holding the distance limit.
`timescale 1ns / 1ps

module ncl_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ncl_pkg::APB_AW-1:0]   paddr,
    input  logic [ncl_pkg::APB_DW-1:0]   pwdata,
    output logic [ncl_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [ncl_pkg::LIMIT_W-1:0]  o_limit
);
    import ncl_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               wr_limit;

    assign pready   = 1'b1;
    assign wr_limit = psel && penable && pwrite && (paddr[2] == REG_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (wr_limit) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LIMIT) begin
            prdata = {{(APB_DW-LIMIT_W){1'b0}}, r_limit};
        end
    end

    assign o_limit = r_limit;

endmodule

/* design/ncl_mem.sv */
// Centroid table: one write port, one read port with registered data.
`timescale 1ns / 1ps

module ncl_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ncl_ctrl.sv */
// Request sequencer: table fill, distance scan pipeline and result register.
`timescale 1ns / 1ps

module ncl_ctrl #(
    parameter int MAX_CENTROIDS = 128,
    parameter int IW            = 7,
    parameter int CW            = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ncl_pkg::t_ncl_req           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ncl_pkg::t_ncl_rsp           o_out_data,
    input  logic [ncl_pkg::LIMIT_W-1:0] i_limit,
    output logic                        o_we,
    output logic [IW-1:0]               o_waddr,
    output logic [2*CW-1:0]             o_wdata,
    output logic [IW-1:0]               o_raddr,
    input  logic [2*CW-1:0]             i_rdata
);
    import ncl_pkg::*;

    localparam int CNT_W = $clog2(MAX_CENTROIDS + 1);
    localparam int DW    = 2 * CW + 1;

    t_ncl_state         r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [IW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_qx, r_qy;
    logic               r_p1_vld, r_p2_vld;
    logic [IW-1:0]      r_p1_idx, r_p2_idx;
    logic [DW-1:0]      r_dist;
    logic [LIMIT_W-1:0] r_best;
    logic [IW-1:0]      r_best_idx;
    logic               r_hit;
    logic               r_out_valid;
    t_ncl_rsp           r_out;

    logic               in_stall, in_acc, issue, load_out, last, room;
    logic [CW-1:0]      rx, ry, dx, dy;
    logic [2*CW-1:0]    sqx, sqy;
    logic [DW-1:0]      sum_sq;
    logic               closer;
    logic [IW+NIDX_W-1:0] idx_wide;

    assign in_acc = i_in_valid && !in_stall;
    assign last   = (CNT_W'(r_rd_idx) == (r_count - CNT_W'(1)));
    assign room   = (r_count < CNT_W'(MAX_CENTROIDS));

    always_comb begin
        n_state  = r_state;
        in_stall = 1'b1;
        issue    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_stall = 1'b0;
                if (i_in_valid && (i_in_data.req_type == REQ_QUERY)) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue = 1'b1;
                if (last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Table write on append while there is room
    assign o_we    = in_acc && (i_in_data.req_type == REQ_APPEND) && room;
    assign o_waddr = r_count[IW-1:0];
    assign o_wdata = {i_in_data.coord_x[CW-1:0], i_in_data.coord_y[CW-1:0]};
    assign o_raddr = r_rd_idx;

    // Squared distance of the entry just read
    assign rx     = i_rdata[2*CW-1:CW];
    assign ry     = i_rdata[CW-1:0];
    assign dx     = (rx >= r_qx) ? (rx - r_qx) : (r_qx - rx);
    assign dy     = (ry >= r_qy) ? (ry - r_qy) : (r_qy - ry);
    assign sqx    = dx * dx;
    assign sqy    = dy * dy;
    assign sum_sq = DW'(sqx) + DW'(sqy);

    assign closer = r_p2_vld && (LIMIT_W'(r_dist) < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            if (in_acc && (i_in_data.req_type == REQ_CLEAR)) begin
                r_count <= '0;
            end else if (o_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign idx_wide = {{NIDX_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.req_type == REQ_QUERY)) begin
            r_qx       <= i_in_data.coord_x[CW-1:0];
            r_qy       <= i_in_data.coord_y[CW-1:0];
            r_rd_idx   <= '0;
            r_best     <= i_limit;
            r_best_idx <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (issue && !last) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
            if (closer) begin
                r_best     <= LIMIT_W'(r_dist);
                r_best_idx <= r_p2_idx;
                r_hit      <= 1'b1;
            end
        end
        r_p1_idx <= r_rd_idx;
        r_p2_idx <= r_p1_idx;
        r_dist   <= sum_sq;
        if (load_out) begin
            r_out.nearest_index <= idx_wide[NIDX_W-1:0];
            r_out.found         <= r_hit;
        end
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CENTROIDS))
        else $error("centroid count beyond table depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("scan read past stored centroids");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> $past(r_p1_vld))
        else $error("distance stage valid without a read");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_p1_vld && !r_p2_vld))
        else $error("result taken while scan pipeline busy");

    a_hit_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) && r_hit) |-> (r_best < i_limit))
        else $error("chosen distance not below limit");
`endif

endmodule

/* design/nearest_centroid_labeler.sv */
// Top level of the nearest centroid labeler.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   i_in_data   (t_ncl_req)
// out       source     o_out_valid / i_out_stall o_out_data  (t_ncl_rsp)
// apb       sink       psel / penable / pready   paddr, pwdata, prdata
//
// A query against N stored centroids makes one table read per cycle on the
// single read port, then passes two pipeline stages and a wrap-up step.
// A query on an empty table skips the scan and goes straight to its result.
// Synchronous active-low reset empties the table and sets the limit to 20000.
// A result held by a stalled output waits in its register while the next
// request is already taken.

module nearest_centroid_labeler #(
    parameter int MAX_CENTROIDS = 128,
    parameter int COORD_BITS    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ncl_pkg::t_ncl_req          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ncl_pkg::t_ncl_rsp          o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ncl_pkg::APB_AW-1:0] paddr,
    input  logic [ncl_pkg::APB_DW-1:0] pwdata,
    output logic [ncl_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import ncl_pkg::*;

    // Table address width and stored coordinate width
    localparam int IW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

    logic [LIMIT_W-1:0] limit;
    logic               we;
    logic [IW-1:0]      waddr, raddr;
    logic [2*CW-1:0]    wdata, rdata;

    // Configuration registers
    ncl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (limit)
    );

    // Centroid storage, one packed x,y entry per index
    ncl_mem #(
        .DEPTH (MAX_CENTROIDS),
        .AW    (IW),
        .DW    (2 * CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Request handling and the nearest-centroid scan
    ncl_ctrl #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .IW            (IW),
        .CW            (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_limit     (limit),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

endmodule

/* bench/nearest_centroid_labeler_test.sv */
// Self-checking testbench for the nearest centroid labeler: random traffic, APB setup, scoreboard.
`timescale 1ns / 1ps

module nearest_centroid_labeler_test;

    import ncl_pkg::*;

    localparam int MAX_CENTROIDS = 128;
    localparam int ITEM_BUDGET   = 850;
    localparam int SETTLE_CYCLES = 12;
    localparam int RUN_LIMIT_NS  = 10_000_000;
    localparam int PHASES        = 8;

    // Request code that the block must ignore
    localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;

    // Byte addresses on the APB port; bit 2 selects the register
    localparam logic [APB_AW-1:0] LIMIT_ADDR  = {REG_LIMIT, 2'b00};
    localparam logic [APB_AW-1:0] NO_REG_ADDR = {~REG_LIMIT, 2'b00};

    // Scoreboard: mirrors the centroid table and the limit, and queues the labels
    // that each accepted query must produce, oldest first.
    class label_scoreboard;
        logic [COORD_W-1:0] table_x [MAX_CENTROIDS];
        logic [COORD_W-1:0] table_y [MAX_CENTROIDS];
        int unsigned        stored;
        logic [LIMIT_W-1:0] limit;
        t_ncl_rsp           awaited[$];
        int unsigned        mismatches;

        function new();
            stored     = 0;
            limit      = LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void set_limit(logic [APB_DW-1:0] value);
            limit = value[LIMIT_W-1:0];
        endfunction

        // Apply one accepted request to the mirror; queue a label for a query.
        function void note_request(t_ncl_req req);
            logic [17:0]        best;
            logic [17:0]        span_sq;
            logic [COORD_W-1:0] dx;
            logic [COORD_W-1:0] dy;
            logic [NIDX_W-1:0]  pick;
            logic               hit;
            t_ncl_rsp           label;
            case (req.req_type)
                REQ_CLEAR: begin
                    stored = 0;
                end
                REQ_APPEND: begin
                    if (stored < MAX_CENTROIDS) begin
                        table_x[stored] = req.coord_x;
                        table_y[stored] = req.coord_y;
                        stored++;
                    end
                end
                REQ_QUERY: begin
                    best = {1'b0, limit};
                    pick = '0;
                    hit  = 1'b0;
                    for (int i = 0; i < stored; i++) begin
                        dx = (req.coord_x >= table_x[i]) ? req.coord_x - table_x[i]
                                                         : table_x[i] - req.coord_x;
                        dy = (req.coord_y >= table_y[i]) ? req.coord_y - table_y[i]
                                                         : table_y[i] - req.coord_y;
                        span_sq = 18'(dx) * 18'(dx) + 18'(dy) * 18'(dy);
                        if (span_sq < best) begin
                            best = span_sq;
                            pick = NIDX_W'(i);
                            hit  = 1'b1;
                        end
                    end
                    label.nearest_index = pick;
                    label.found         = hit;
                    awaited = {awaited, label};
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] label check: %s", $time, what);
        endtask

        // Compare one accepted label with the oldest one waiting.
        task check_result(t_ncl_rsp got);
            t_ncl_rsp want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("label with none awaited: index %0d found %0b",
                                          got.nearest_index, got.found));
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found is %0b, want %0b", got.found, want.found));
            if (got.nearest_index !== want.nearest_index)
                report_mismatch($sformatf("nearest_index is %0d, want %0d",
                                          got.nearest_index, want.nearest_index));
        endtask
    endclass

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    t_ncl_req           in_data   = '0;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [APB_AW-1:0]  paddr     = '0;
    logic [APB_DW-1:0]  pwdata    = '0;
    logic               in_stall;
    logic               out_valid;
    t_ncl_rsp           out_data;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    label_scoreboard    sb = new();

    // Quiet modes: no input gaps / no output stalls for a whole stretch of traffic
    logic               calm_in  = 1'b0;
    logic               calm_out = 1'b0;
    int                 stall_left = 0;
    int                 sent = 0;
    t_ncl_req           placed[$];

    nearest_centroid_labeler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle length from three bands: mostly the shortest, sometimes the middle one, rarely a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Move a coordinate by up to span in either direction, clamped to the field range.
    function automatic logic [COORD_W-1:0] jitter(logic [COORD_W-1:0] c, int span);
        int v;
        v = int'(c) + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return COORD_W'(v);
    endfunction

    // Output side: check every label transfer, and stall in random bursts.
    // Outputs are read at the edge before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            if (!calm_out && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // Offer one request and hold it until the transfer. Called at a rising edge;
    // valid stays high across back-to-back requests, so it takes one assignment per step.
    task automatic send_req(input t_ncl_req req);
        int gap;
        gap = (calm_in || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (in_stall);
        sb.note_request(req);
        if (req.req_type != REQ_UNUSED)
            sent++;
    endtask

    task automatic send_item(input logic [REQ_W-1:0] kind, input int x, input int y);
        t_ncl_req req;
        req.req_type = kind;
        req.coord_x  = COORD_W'(x);
        req.coord_y  = COORD_W'(y);
        if (kind == REQ_CLEAR)
            placed.delete();
        else if (kind == REQ_APPEND && placed.size() < MAX_CENTROIDS)
            placed = {placed, req};
        send_req(req);
    endtask

    // Drop valid, wait for every awaited label, then give the block time to finish
    // a trailing clear or append.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase until pready, then back to idle.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_LIMIT)
            sb.set_limit(data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read the limit back and compare it with the mirror.
    task automatic apb_read_limit();
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIMIT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got[LIMIT_W-1:0] !== sb.limit)
            sb.report_mismatch($sformatf("limit reads %0d, want %0d",
                                         got[LIMIT_W-1:0], sb.limit));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sometimes slip in a request the block must ignore.
    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 4)
            send_item(REQ_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // One episode: usually clear, load some centroids (now and then the whole table
    // and past it), then query tiles mostly close to the loaded points.
    task automatic run_episode();
        int       r;
        int       n_app;
        int       n_qry;
        int       span;
        t_ncl_req p;
        calm_in  = ($urandom_range(0, 4) == 0);
        calm_out = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 4) begin
            send_item(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
            n_app = $urandom_range(125, 134);
        end else begin
            if (r < 85)
                send_item(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
            n_app = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        end
        for (int i = 0; i < n_app; i++) begin
            maybe_noise();
            r = $urandom_range(0, 99);
            if (placed.size() != 0 && r < 15) begin
                p = placed[$urandom_range(0, placed.size() - 1)];
                send_item(REQ_APPEND, p.coord_x, p.coord_y);
            end else if (placed.size() != 0 && r < 55) begin
                p = placed[placed.size() - 1];
                send_item(REQ_APPEND, jitter(p.coord_x, 20), jitter(p.coord_y, 20));
            end else begin
                send_item(REQ_APPEND, $urandom_range(0, 255), $urandom_range(0, 255));
            end
        end
        n_qry = $urandom_range(1, 8);
        for (int i = 0; i < n_qry; i++) begin
            maybe_noise();
            r = $urandom_range(0, 99);
            if (placed.size() != 0 && r < 70) begin
                p = placed[$urandom_range(0, placed.size() - 1)];
                r = $urandom_range(0, 3);
                span = (r == 0) ? 0 : (r == 3) ? 60 : 12;
                send_item(REQ_QUERY, jitter(p.coord_x, span), jitter(p.coord_y, span));
            end else if (r < 80) begin
                send_item(REQ_QUERY, $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255);
            end else begin
                send_item(REQ_QUERY, $urandom_range(0, 255), $urandom_range(0, 255));
            end
        end
    endtask

    // Stop a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [APB_DW-1:0] phase_limits[PHASES];
        int                phase_goal;

        // Walk the limit through zero, all ones (masked to the top), one, small,
        // the reset value and random settings.
        phase_limits = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd300, 32'd2000, 32'd20000,
                         32'd0, 32'd0};
        phase_limits[6] = $urandom();
        phase_limits[7] = $urandom_range(5000, 60000);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset limit.
        send_item(REQ_QUERY, 10, 10);        // empty table: nothing found
        send_item(REQ_UNUSED, 255, 255);     // ignored request code
        send_item(REQ_APPEND, 0, 0);
        send_item(REQ_APPEND, 255, 255);
        send_item(REQ_APPEND, 255, 0);
        send_item(REQ_APPEND, 0, 255);
        send_item(REQ_APPEND, 128, 128);
        send_item(REQ_APPEND, 128, 128);     // duplicate: tie must go to the lower index
        send_item(REQ_QUERY, 0, 0);
        send_item(REQ_QUERY, 255, 255);
        send_item(REQ_QUERY, 128, 128);
        send_item(REQ_QUERY, 200, 60);
        send_item(REQ_QUERY, 64, 192);
        send_item(REQ_CLEAR, 0, 0);
        send_item(REQ_QUERY, 0, 0);          // stale entries must stay unread
        send_item(REQ_APPEND, 77, 33);
        send_item(REQ_QUERY, 255, 0);        // beyond the limit
        send_item(REQ_QUERY, 77, 33);
        settle();

        // A write to an unmapped address must leave the limit alone.
        apb_write(NO_REG_ADDR, 32'd0);
        apb_read_limit();
        send_item(REQ_QUERY, 77, 33);
        settle();

        // Random phases, each under its own limit.
        for (int ph = 0; ph < PHASES; ph++) begin
            apb_write(LIMIT_ADDR, phase_limits[ph]);
            apb_read_limit();
            phase_goal = sent + ITEM_BUDGET / PHASES;
            while (sent < phase_goal)
                run_episode();
            settle();
        end

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
